@@ hdl/sha256_stream_hasher_assert.svh @@
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication check on the rising clock, disabled in reset
`define SHA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication check
`define SHA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

@@ hdl/sha256_pkg.sv @@
package sha256_pkg;

   localparam logic REQ_ABSORB = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_type_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ hdl/sha256_stream_hasher.sv @@
// SHA-256 hasher over a byte stream.
// req channel (valid/ready): req_type 0 absorbs data_byte, 1 finishes the
// message. rsp channel (valid/ready): eight digest words, index 0 first,
// last_word set on the eighth.
// An absorb that does not fill a block leaves req_ready high. One that fills
// a 64-byte block starts a compression: the block moves into the 16-word
// schedule window, one round unit then runs one round per cycle, and the
// result is added into the chaining words. A finish writes the padding one
// byte per cycle (up to 64 bytes, or 72 with a spill block) and runs one or
// two compressions; then the digest words go out one per cycle while the
// receiver takes them. The rate is set by the single round unit.
// req_ready is low throughout that work.
// A receiver stall holds the word index, and so the current word, until
// it is taken; nothing else advances.
// Reset (synchronous, active high) restores the initial chaining words,
// clears the fill count and bit length and drops any pending word. The
// block buffer needs no clearing: every byte is written before it is read.
module sha256_stream_hasher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sha256_pkg::req_type_type   req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sha256_pkg::rsp_type        rsp_data
);
   import sha256_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [31:0] buf_ff [16];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [63:0] total_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  rnd_ff;
   logic [4:0]  ld_ff;
   logic        final_ff;
   logic        spill_ff;
   logic [2:0]  idx_ff;
   logic        rsp_valid_ff;

   logic [31:0] t1, t2, wnew, wcur, s0, s1;
   logic [7:0]  pad_byte;
   logic [2:0]  len_sel;
   logic [1:0]  byte_lane;

   assign wcur = w_ff[0];
   always_comb begin
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      t1   = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
           + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[rnd_ff] + wcur;
      t2   = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      // first byte of a word lands in its top lane
      byte_lane = ~fill_ff[1:0];
      len_sel = 3'(~fill_ff[2:0]);
      if (fill_ff >= 6'd56 && !spill_ff) begin
         pad_byte = total_ff[8*len_sel +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.digest_word = h_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == REQ_ABSORB) begin
                  buf_ff[fill_ff[5:2]][{byte_lane, 3'd0} +: 8] <= req_data.data_byte;
                  fill_ff <= fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     final_ff <= 1'b0;
                     ld_ff    <= '0;
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  total_ff <= bits_ff + {55'd0, fill_ff, 3'd0};
                  buf_ff[fill_ff[5:2]][{byte_lane, 3'd0} +: 8] <= 8'h80;
                  spill_ff <= (fill_ff >= 6'd56);
                  fill_ff  <= fill_ff + 6'd1;
                  final_ff <= 1'b1;
                  state_ff <= (fill_ff == 6'd63) ? ST_LOAD : ST_PAD;
                  ld_ff    <= '0;
               end
            end
         end
         ST_PAD: begin
            // write zeros, and the length in the last eight bytes of the final block
            buf_ff[fill_ff[5:2]][{byte_lane, 3'd0} +: 8] <= pad_byte;
            fill_ff <= fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               ld_ff    <= '0;
               state_ff <= ST_LOAD;
            end
         end
         ST_LOAD: begin
            // one big-endian schedule word per cycle
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= buf_ff[ld_ff[3:0]];
            ld_ff <= ld_ff + 5'd1;
            if (ld_ff == 5'd15) begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               rnd_ff   <= '0;
               state_ff <= ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= wnew;
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            rnd_ff <= rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_ff <= ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            if (!final_ff) begin
               bits_ff  <= bits_ff + 64'd512;
               state_ff <= ST_IDLE;
            end else if (spill_ff) begin
               spill_ff <= 1'b0;
               state_ff <= ST_PAD;
            end else begin
               idx_ff       <= '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  rsp_valid_ff <= 1'b0;
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                  bits_ff  <= '0;
                  fill_ff  <= '0;
                  state_ff <= ST_IDLE;
               end
            end
         end
         default: state_ff <= ST_IDLE;
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         spill_ff     <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end
   end

endmodule

@@ hdl/sha256_stream_hasher_checker.sv @@
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sha256_pkg::rsp_type   rsp_data
);
   import sha256_pkg::*;

   `SHA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready while emitting")
   `SHA_ASSERT_IMP(a_start_zero, clock, reset, $rose(rsp_valid), rsp_data.word_index == 3'd0,
      "digest does not start at word 0")
   `SHA_ASSERT_NEXT(a_advance, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_word,
      rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1,
      "digest word skipped")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
      "stalled word changed")

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
